FILE: sv/dchs_pkg.sv
`default_nettype none

package dchs_pkg;

  // Default accumulator width
  localparam int DEFAULT_WORD_BITS = 32;

  // Character codes
  localparam logic [7:0] CHAR_END   = 8'h00;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Config register indexes
  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HEADS   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SECTORS = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARES  = 2'd2;

  // Entries in the address queue
  localparam int QUEUE_DEPTH = 2;

  // Field currently being parsed
  typedef enum logic [1:0] {
    PH_CYL  = 2'd0,
    PH_HEAD = 2'd1,
    PH_BLK  = 2'd2
  } phase_e;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_MUL   = 2'd1,
    BK_SCALE = 2'd2,
    BK_SUM   = 2'd3
  } bk_state_e;

  // Disk geometry
  typedef struct packed {
    logic [7:0]  heads;
    logic [15:0] sectors;
    logic [15:0] spares;
  } geom_t;

  // One parsed address, fields already reduced to the result width
  typedef struct packed {
    logic [31:0] cyl;
    logic [31:0] head;
    logic [31:0] blk;
    logic        err;
  } job_t;

endpackage

`default_nettype wire

FILE: sv/dchs_front.sv
`default_nettype none

module dchs_front
  import dchs_pkg::*;
#(
  parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] symbol_i,
  output logic            push_o,
  output job_t            job_o
);

  localparam int RES_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;

  phase_e                 phase_q, phase_d;
  logic [WORD_BITS-1:0]   cyl_q, cyl_d;
  logic [WORD_BITS-1:0]   head_q, head_d;
  logic [WORD_BITS-1:0]   blk_q, blk_d;
  logic                   err_q, err_d;
  logic                   slash_q, slash_d;

  logic                   is_end, is_digit, is_slash;
  logic [WORD_BITS-1:0]   digit;
  logic [WORD_BITS-1:0]   acc_sel, acc_next;

  // Classify the item
  assign is_end   = (symbol_i == CHAR_END);
  assign is_digit = (symbol_i >= CHAR_ZERO) && (symbol_i <= CHAR_NINE);
  assign is_slash = (symbol_i == CHAR_SLASH);
  assign digit    = WORD_BITS'(symbol_i - CHAR_ZERO);

  // acc * 10 + d as shift-add, wraps at the word width
  always_comb begin
    case (phase_q)
      PH_CYL:  acc_sel = cyl_q;
      PH_HEAD: acc_sel = head_q;
      default: acc_sel = blk_q;
    endcase
    acc_next = (acc_sel << 3) + (acc_sel << 1) + digit;
  end

  // Parser state update
  always_comb begin
    phase_d = phase_q;
    cyl_d   = cyl_q;
    head_d  = head_q;
    blk_d   = blk_q;
    err_d   = err_q;
    slash_d = slash_q;
    if (accept_i) begin
      if (is_end) begin
        phase_d = PH_CYL;
        cyl_d   = '0;
        head_d  = '0;
        blk_d   = '0;
        err_d   = 1'b0;
        slash_d = 1'b0;
      end else if (!err_q) begin
        if (is_digit) begin
          case (phase_q)
            PH_CYL:  cyl_d  = acc_next;
            PH_HEAD: head_d = acc_next;
            default: blk_d  = acc_next;
          endcase
        end else if (is_slash && (phase_q != PH_BLK)) begin
          phase_d = (phase_q == PH_CYL) ? PH_HEAD : PH_BLK;
          slash_d = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CYL;
      cyl_q   <= '0;
      head_q  <= '0;
      blk_q   <= '0;
      err_q   <= 1'b0;
      slash_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cyl_q   <= cyl_d;
      head_q  <= head_d;
      blk_q   <= blk_d;
      err_q   <= err_d;
      slash_q <= slash_d;
    end
  end

  // Terminator hands the address to the queue; bare number is the block
  assign push_o = accept_i && is_end;

  always_comb begin
    job_o.head = 32'(head_q[RES_BITS-1:0]);
    job_o.err  = err_q;
    if (slash_q) begin
      job_o.cyl = 32'(cyl_q[RES_BITS-1:0]);
      job_o.blk = 32'(blk_q[RES_BITS-1:0]);
    end else begin
      job_o.cyl = '0;
      job_o.blk = 32'(cyl_q[RES_BITS-1:0]);
    end
  end

endmodule

`default_nettype wire

FILE: sv/dchs_queue.sv
`default_nettype none

module dchs_queue
  import dchs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      pop_data_o,
  output logic      empty_o
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t                entries_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entries_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/dchs_back.sv
`default_nettype none

module dchs_back
  import dchs_pkg::*;
#(
  parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire geom_t  geom_i,
  input  wire logic   empty_i,
  input  wire job_t   job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [31:0] block_number_o,
  output logic        bad_syntax_o
);

  localparam int RES_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic [31:0] RES_MASK =
    (RES_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << RES_BITS) - 64'd1);

  bk_state_e   state_q, state_d;
  job_t        job_q;
  logic [23:0] track_prod_q;
  logic [31:0] head_prod_q;
  logic [31:0] cyl_prod_q;
  logic [31:0] per_cyl;
  logic [31:0] total;
  logic        out_valid_q;
  logic [31:0] out_block_q;
  logic        out_err_q;
  logic        out_free;
  logic        load_out;

  assign out_free = !out_valid_q || out_ready_i;
  assign per_cyl  = 32'(track_prod_q) - 32'(geom_i.spares);
  assign total    = (cyl_prod_q + head_prod_q + job_q.blk) & RES_MASK;

  // Sequencer: take job, two multiply steps, final sum into output register
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_MUL;
        end
      end
      BK_MUL:   state_d = BK_SCALE;
      BK_SCALE: state_d = BK_SUM;
      BK_SUM: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == BK_MUL) begin
      track_prod_q <= geom_i.heads * geom_i.sectors;
      head_prod_q  <= 32'(job_q.head * 32'(geom_i.sectors));
    end
    if (state_q == BK_SCALE) begin
      cyl_prod_q <= 32'(job_q.cyl * per_cyl);
    end
    if (load_out) begin
      out_block_q <= total;
      out_err_q   <= job_q.err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_number_o = out_block_q;
  assign bad_syntax_o   = out_err_q;

  // A job taken from the queue starts the multiply steps next cycle
  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == BK_MUL))
    else $error("pop did not start multiply step");

  // Nothing is taken from an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  // A finished sum always shows up as a result
  a_sum_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o)
    else $error("sum not presented");

  // Sequencer only pops while idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == BK_IDLE))
    else $error("pop outside idle");

endmodule

`default_nettype wire

FILE: sv/disk_chs_address_parser_unit.sv
`default_nettype none

// Disk address parser. Takes the address text "cyl/head/block" or a bare block
// number one character per item on s_axis, ended by a zero character, and
// returns one result per terminator on m_axis: the linear block
// cyl*(heads*sectors-spares)+head*sectors+block modulo 2^min(WORD_BITS,32),
// with a sticky syntax error flag in tuser. The front end accepts one
// character per cycle whenever the two-entry address queue has room. The
// back end sequencer works on one address at a time (queue pop, two multiply
// steps, final sum, which waits for m_axis to be free), so a run of short
// addresses can fill the queue and stall s_axis. Geometry registers are to be
// written on the cfg port only while no address is in flight; the user must
// keep to this, as the block itself does not enforce it.

module disk_chs_address_parser_unit
  import dchs_pkg::*;
#(
  parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  wire logic [15:0]              cfg_wdata_i,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [7:0]               s_axis_tdata,  // [7:0] symbol
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [31:0] block_number
  output logic                          m_axis_tuser   // [0] bad_syntax
);

  geom_t geom_q;
  logic  s_accept;
  logic  push, full, pop, empty;
  job_t  push_job, pop_job;

  // Geometry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.heads   <= 8'd1;
      geom_q.sectors <= 16'd1;
      geom_q.spares  <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_HEADS:   geom_q.heads   <= cfg_wdata_i[7:0];
        REG_SECTORS: geom_q.sectors <= cfg_wdata_i;
        REG_SPARES:  geom_q.spares  <= cfg_wdata_i;
        default:     geom_q         <= geom_q;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  dchs_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_accept),
    .symbol_i (s_axis_tdata),
    .push_o   (push),
    .job_o    (push_job)
  );

  dchs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  dchs_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .geom_i         (geom_q),
    .empty_i        (empty),
    .job_i          (pop_job),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .block_number_o (m_axis_tdata),
    .bad_syntax_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire
